// ----- hdl/wir_pkg.sv -----
// -----------------------------------------------------------------------------
// wir_pkg: shared types and codes for the weighted isotonic regression block
// Request and result beat layouts, request codes and read status codes.
// -----------------------------------------------------------------------------
package wir_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] sample_key;
    logic signed [31:0] sample_value;
    logic [15:0]        sample_weight;
    logic               final_point;
    logic [7:0]         read_slot;
  } wir_in_t;

  typedef struct packed {
    logic signed [31:0] fitted_value;
    logic [7:0]         slot_echo;
    logic [1:0]         read_status;
  } wir_out_t;

endpackage

// ----- hdl/wir_div.sv -----
// -----------------------------------------------------------------------------
// wir_div: serial floor divider
// Divides a signed sum by a positive weight, one quotient bit per cycle, and
// returns the floored quotient truncated to 32 bits.
// -----------------------------------------------------------------------------
module wir_div #(
  parameter int SW  = 58,
  parameter int BWW = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [SW-1:0]  sum,
  input  logic [BWW-1:0]        wsum,
  output logic                  done,
  output logic signed [31:0]    quot
);
  localparam int UW = SW - 1;
  localparam int NW = $clog2(UW + 1);

  logic          neg;
  logic [UW-1:0] u;
  logic [BWW:0]  rem;
  logic [BWW-1:0] dvs;
  logic [NW-1:0] steps;
  logic          running;
  logic [BWW:0]  rem_sh;
  logic          fits;

  assign rem_sh = {rem[BWW-1:0], u[UW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // For a negative sum, floor(s/w) equals the complement of (~s)/w.
  assign quot = neg ? ~u[31:0] : u[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg     <= sum[SW-1];
        u       <= sum[SW-1] ? ~sum[UW-1:0] : sum[UW-1:0];
        rem     <= '0;
        dvs     <= wsum;
        steps   <= NW'(UW);
        running <= 1'b1;
      end else if (running) begin
        rem   <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        u     <= {u[UW-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == NW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/weighted_isotonic_regression.sv -----
// -----------------------------------------------------------------------------
// weighted_isotonic_regression: weighted isotonic fit by pooling violators
// Loads weighted points, sorts them, pools adjacent violators and answers
// fitted-value reads in load order.
// -----------------------------------------------------------------------------
// Usage: a request beat is taken on a rising edge with start high and busy low.
// A load beat (req_type 0) stores one point and produces no result; loads
// past MAX_SAMPLES are dropped. A load with final_point set makes the block
// busy while it fits. The first load after a fit starts a new set.
// A read beat (req_type 1) is answered in the next cycle: result_valid is high
// for exactly one cycle with the result beat, and busy is high in that same
// cycle. The receiver cannot stall; results must be taken as shown.
// A fit runs the insertion sort, then pooling, which merges violating blocks
// through the one-bit-per-cycle divider on SW-bit sums, where SW = 50 +
// log2(MAX_SAMPLES), then the final spread of block means back to points.
// Reset clears the count and the fit flag; the stores need no clearing.
// -----------------------------------------------------------------------------
module weighted_isotonic_regression #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wir_pkg::wir_in_t  req,
  output logic              result_valid,
  output wir_pkg::wir_out_t result
);
  import wir_pkg::*;

  localparam int IW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int XW  = (CW > 8) ? CW : 8;
  localparam int BWW = 16 + IW;
  localparam int PW  = 32 + BWW + 1;
  localparam int SW  = PW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP,
    S_SORT_I, S_SORT_CUR, S_SORT_STEP, S_SORT_ORD, S_SORT_CMP,
    S_POOL_I, S_POOL_ORD, S_POOL_PUSH, S_POOL_CHK, S_POOL_CMP,
    S_MUL2, S_SUM, S_DIV,
    S_FLUSH, S_UN_B, S_UN_LD, S_UN_P, S_UN_W
  } state_t;

  state_t state;

  // Stores.
  logic signed [31:0] key_mem   [MAX_SAMPLES];
  logic signed [31:0] val_mem   [MAX_SAMPLES];
  logic [15:0]        wt_mem    [MAX_SAMPLES];
  logic [IW-1:0]      ord_mem   [MAX_SAMPLES];
  logic signed [31:0] bm_mem    [MAX_SAMPLES];
  logic [BWW-1:0]     bw_mem    [MAX_SAMPLES];
  logic [CW-1:0]      bs_mem    [MAX_SAMPLES];
  logic signed [31:0] fit_mem   [MAX_SAMPLES];

  logic signed [31:0] key_rd, val_rd, bm_rd, fit_rd;
  logic [15:0]        wt_rd;
  logic [IW-1:0]      ord_rd;
  logic [BWW-1:0]     bw_rd;
  logic [CW-1:0]      bs_rd;

  // Control registers.
  logic [CW-1:0]      loaded_count;
  logic               fit_ready;
  logic [CW-1:0]      i, j, cnt, rem;
  logic signed [31:0] cur_key, cur_val;
  logic [IW-1:0]      ord_a;
  logic signed [31:0] t_mean;
  logic [BWW-1:0]     t_w;
  logic [CW-1:0]      t_size;
  logic signed [PW-1:0] prod, acc;
  logic signed [SW-1:0] sum;
  logic [BWW-1:0]     wsum;
  logic [1:0]         rsp_status;
  logic [7:0]         rsp_slot;

  // Request decode.
  logic               accept;
  logic [CW-1:0]      eff_cnt;
  logic               load_wr;
  logic [XW-1:0]      slot_x;

  assign accept  = start && !busy;
  assign eff_cnt = fit_ready ? '0 : loaded_count;
  assign load_wr = accept && (req.req_type == REQ_LOAD) && (eff_cnt < CW'(MAX_SAMPLES));
  assign slot_x  = XW'(req.read_slot);

  // Memory port control.
  logic               kv_re;
  logic [IW-1:0]      kv_raddr;
  logic               ord_re, ord_we;
  logic [IW-1:0]      ord_raddr, ord_waddr, ord_wdata;
  logic               blk_re, blk_we;
  logic [IW-1:0]      blk_raddr, blk_waddr;
  logic               fit_re, fit_we;
  logic [CW-1:0]      jm1, cntm1, cntm2;
  logic               after;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] mul_a;
  logic [BWW-1:0]     mul_b;

  assign jm1   = j - 1'b1;
  assign cntm1 = cnt - 1'b1;
  assign cntm2 = cnt - CW'(2);
  assign after = (key_rd > cur_key) || ((key_rd == cur_key) && (val_rd > cur_val));

  always_comb begin
    kv_re     = 1'b0;
    kv_raddr  = i[IW-1:0];
    ord_re    = 1'b0;
    ord_raddr = i[IW-1:0];
    ord_we    = 1'b0;
    ord_waddr = j[IW-1:0];
    ord_wdata = i[IW-1:0];
    blk_re    = 1'b0;
    blk_raddr = cntm2[IW-1:0];
    blk_we    = 1'b0;
    blk_waddr = cntm1[IW-1:0];
    fit_re    = accept && (req.req_type == REQ_READ);
    fit_we    = 1'b0;
    mul_a     = t_mean;
    mul_b     = t_w;
    case (state)
      S_SORT_I:    kv_re = (i != loaded_count);
      S_SORT_STEP: begin
        if (j == '0) begin
          ord_we = 1'b1;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = jm1[IW-1:0];
        end
      end
      S_SORT_ORD: begin
        kv_re    = 1'b1;
        kv_raddr = ord_rd;
      end
      S_SORT_CMP: begin
        ord_we    = 1'b1;
        ord_wdata = after ? ord_a : i[IW-1:0];
      end
      S_POOL_I:    ord_re = (i != loaded_count);
      S_POOL_ORD: begin
        kv_re    = 1'b1;
        kv_raddr = ord_rd;
      end
      S_POOL_PUSH: blk_we = (cnt != '0);
      S_POOL_CHK:  blk_re = (cnt > CW'(1));
      S_MUL2: begin
        mul_a = bm_rd;
        mul_b = bw_rd;
      end
      S_FLUSH:     blk_we = 1'b1;
      S_UN_B: begin
        blk_re    = (i != cnt);
        blk_raddr = i[IW-1:0];
      end
      S_UN_P: begin
        ord_re    = (rem != '0);
        ord_raddr = j[IW-1:0];
      end
      S_UN_W:      fit_we = 1'b1;
      default: ;
    endcase
  end

  // Point stores.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      key_mem[eff_cnt[IW-1:0]] <= req.sample_key;
      val_mem[eff_cnt[IW-1:0]] <= req.sample_value;
      wt_mem[eff_cnt[IW-1:0]]  <= (req.sample_weight == '0) ? 16'd1 : req.sample_weight;
    end
    if (kv_re) begin
      key_rd <= key_mem[kv_raddr];
      val_rd <= val_mem[kv_raddr];
      wt_rd  <= wt_mem[kv_raddr];
    end
  end

  // Sorted order store.
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rd <= ord_mem[ord_raddr];
    end
  end

  // Block stack below the top block, which lives in t_mean, t_w and t_size.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      bm_mem[blk_waddr] <= t_mean;
      bw_mem[blk_waddr] <= t_w;
      bs_mem[blk_waddr] <= t_size;
    end
    if (blk_re) begin
      bm_rd <= bm_mem[blk_raddr];
      bw_rd <= bw_mem[blk_raddr];
      bs_rd <= bs_mem[blk_raddr];
    end
  end

  // Fitted values in load order.
  always_ff @(posedge clk) begin
    if (fit_we) begin
      fit_mem[ord_rd] <= bm_rd;
    end
    if (fit_re) begin
      fit_rd <= fit_mem[slot_x[IW-1:0]];
    end
  end

  wir_div #(
    .SW  (SW),
    .BWW (BWW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SUM),
    .sum   (SW'(acc) + SW'(prod)),
    .wsum  (t_w + bw_rd),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      fit_ready    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_LOAD) begin
              fit_ready <= 1'b0;
              if (load_wr) begin
                loaded_count <= eff_cnt + 1'b1;
              end else begin
                loaded_count <= eff_cnt;
              end
              if (req.final_point) begin
                i     <= '0;
                state <= S_SORT_I;
              end
            end else begin
              rsp_slot <= req.read_slot;
              if (!fit_ready) begin
                rsp_status <= ST_NOFIT;
              end else if (slot_x >= XW'(loaded_count)) begin
                rsp_status <= ST_RANGE;
              end else begin
                rsp_status <= ST_OK;
              end
              state <= S_RESP;
            end
          end
        end
        S_RESP: state <= S_IDLE;
        S_SORT_I: begin
          if (i == loaded_count) begin
            i     <= '0;
            cnt   <= '0;
            state <= S_POOL_I;
          end else begin
            j     <= i;
            state <= S_SORT_CUR;
          end
        end
        S_SORT_CUR: begin
          cur_key <= key_rd;
          cur_val <= val_rd;
          state   <= S_SORT_STEP;
        end
        S_SORT_STEP: begin
          if (j == '0) begin
            i     <= i + 1'b1;
            state <= S_SORT_I;
          end else begin
            state <= S_SORT_ORD;
          end
        end
        S_SORT_ORD: begin
          ord_a <= ord_rd;
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          // The earlier point moves up one place while it sorts after the new one.
          if (after) begin
            j     <= jm1;
            state <= S_SORT_STEP;
          end else begin
            i     <= i + 1'b1;
            state <= S_SORT_I;
          end
        end
        S_POOL_I: begin
          state <= (i == loaded_count) ? S_FLUSH : S_POOL_ORD;
        end
        S_POOL_ORD: state <= S_POOL_PUSH;
        S_POOL_PUSH: begin
          t_mean <= val_rd;
          t_w    <= BWW'(wt_rd);
          t_size <= CW'(1);
          cnt    <= cnt + 1'b1;
          i      <= i + 1'b1;
          state  <= S_POOL_CHK;
        end
        S_POOL_CHK: state <= (cnt > CW'(1)) ? S_POOL_CMP : S_POOL_I;
        S_POOL_CMP: begin
          if (t_mean < bm_rd) begin
            prod  <= mul_a * $signed({1'b0, mul_b});
            state <= S_MUL2;
          end else begin
            state <= S_POOL_I;
          end
        end
        S_MUL2: begin
          acc   <= prod;
          prod  <= mul_a * $signed({1'b0, mul_b});
          state <= S_SUM;
        end
        S_SUM: begin
          wsum  <= t_w + bw_rd;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            t_mean <= div_q;
            t_w    <= wsum;
            t_size <= t_size + bs_rd;
            cnt    <= cntm1;
            state  <= S_POOL_CHK;
          end
        end
        S_FLUSH: begin
          i     <= '0;
          j     <= '0;
          state <= S_UN_B;
        end
        S_UN_B: begin
          if (i == cnt) begin
            fit_ready <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_UN_LD;
          end
        end
        S_UN_LD: begin
          rem   <= bs_rd;
          state <= S_UN_P;
        end
        S_UN_P: begin
          if (rem == '0) begin
            i     <= i + 1'b1;
            state <= S_UN_B;
          end else begin
            state <= S_UN_W;
          end
        end
        S_UN_W: begin
          j     <= j + 1'b1;
          rem   <= rem - 1'b1;
          state <= S_UN_P;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state != S_IDLE);
  assign result_valid        = (state == S_RESP);
  assign result.fitted_value = (rsp_status == ST_OK) ? fit_rd : '0;
  assign result.slot_echo    = rsp_slot;
  assign result.read_status  = rsp_status;

  // A result beat always answers a read request taken in the previous cycle.
  a_resp_follows_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept && (req.req_type == REQ_READ)))
    else $error("result beat without a read request");

  // An ok status is only given once a fit is complete.
  a_ok_needs_fit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.read_status == ST_OK)) |-> fit_ready)
    else $error("ok status without a fit");

  // The block stack never holds more blocks than points.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_POOL_CHK) |-> (cnt <= loaded_count))
    else $error("block stack deeper than point count");

  // The divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

endmodule
